### hdl/rdiv_pkg.sv
package rdiv_pkg;

  // width of the operand and result ports
  localparam int unsigned FIELD_W = 16;

endpackage

### hdl/rdiv_stage.sv
module rdiv_stage
  import rdiv_pkg::*;
#(
  parameter int unsigned WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  logic [WIDTH-1:0] up_rem,
  input  logic [WIDTH-1:0] up_num,
  input  logic [WIDTH-1:0] up_den,
  input  logic             dn_ready,
  output logic             valid_r,
  output logic [WIDTH-1:0] rem_r,
  output logic [WIDTH-1:0] num_r,
  output logic [WIDTH-1:0] den_r
);

  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;
  logic             take;
  logic [WIDTH-1:0] rem_nxt;
  logic [WIDTH-1:0] num_nxt;

  // stage is free when empty or when its content moves on this cycle
  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    shifted = {up_rem, up_num[WIDTH-1]};
    diff    = shifted - {1'b0, up_den};
    // no borrow: the trial subtraction stands and the quotient bit is one
    take    = !diff[WIDTH];
    rem_nxt = take ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
    // dividend bits leave at the top, quotient bits enter at the bottom
    num_nxt = {up_num[WIDTH-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      rem_r <= rem_nxt;
      num_r <= num_nxt;
      den_r <= up_den;
    end
  end

endmodule

### hdl/restoring_divider.sv
// unsigned restoring divider, one subtract-and-restore row per pipeline stage
// throughput: one operand pair per cycle when not stalled; each stage holds its item under stall
// and a free stage keeps filling while later stages wait
// reset: synchronous active-low rst_n clears all stage valid bits, data is not reset
module restoring_divider
  import rdiv_pkg::*;
#(
  parameter int unsigned WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [FIELD_W-1:0] in_dividend,
  input  logic [FIELD_W-1:0] in_divisor,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [FIELD_W-1:0] out_quotient,
  output logic [FIELD_W-1:0] out_remainder,
  output logic               out_div_by_zero
);

  logic [WIDTH-1:0] num_in;
  logic [WIDTH-1:0] den_in;

  logic             stg_valid [WIDTH];
  logic             stg_ready [WIDTH+1];
  logic [WIDTH-1:0] stg_rem   [WIDTH];
  logic [WIDTH-1:0] stg_num   [WIDTH];
  logic [WIDTH-1:0] stg_den   [WIDTH];

  logic             dz;
  logic [WIDTH-1:0] quo_w;
  logic [WIDTH-1:0] rem_w;

  // operands are taken at WIDTH bits
  generate
    if (WIDTH > FIELD_W) begin : g_in_ext
      assign num_in = {{(WIDTH-FIELD_W){1'b0}}, in_dividend};
      assign den_in = {{(WIDTH-FIELD_W){1'b0}}, in_divisor};
    end else if (WIDTH == FIELD_W) begin : g_in_eq
      assign num_in = in_dividend;
      assign den_in = in_divisor;
    end else begin : g_in_trunc
      assign num_in = in_dividend[WIDTH-1:0];
      assign den_in = in_divisor[WIDTH-1:0];
    end
  endgenerate

  assign stg_ready[WIDTH] = !out_stall;
  assign in_stall         = !stg_ready[0];

  generate
    for (genvar s = 0; s < WIDTH; s++) begin : g_stage
      if (s == 0) begin : g_first
        rdiv_stage #(.WIDTH(WIDTH)) u_stage (
          .clk      (clk),
          .rst_n    (rst_n),
          .up_valid (in_valid),
          .up_ready (stg_ready[s]),
          .up_rem   ({WIDTH{1'b0}}),
          .up_num   (num_in),
          .up_den   (den_in),
          .dn_ready (stg_ready[s+1]),
          .valid_r  (stg_valid[s]),
          .rem_r    (stg_rem[s]),
          .num_r    (stg_num[s]),
          .den_r    (stg_den[s])
        );
      end else begin : g_next
        rdiv_stage #(.WIDTH(WIDTH)) u_stage (
          .clk      (clk),
          .rst_n    (rst_n),
          .up_valid (stg_valid[s-1]),
          .up_ready (stg_ready[s]),
          .up_rem   (stg_rem[s-1]),
          .up_num   (stg_num[s-1]),
          .up_den   (stg_den[s-1]),
          .dn_ready (stg_ready[s+1]),
          .valid_r  (stg_valid[s]),
          .rem_r    (stg_rem[s]),
          .num_r    (stg_num[s]),
          .den_r    (stg_den[s])
        );
      end
    end
  endgenerate

  // zero divisor forces both results to zero
  assign dz    = (stg_den[WIDTH-1] == {WIDTH{1'b0}});
  assign quo_w = dz ? {WIDTH{1'b0}} : stg_num[WIDTH-1];
  assign rem_w = dz ? {WIDTH{1'b0}} : stg_rem[WIDTH-1];

  generate
    if (WIDTH > FIELD_W) begin : g_out_trunc
      assign out_quotient  = quo_w[FIELD_W-1:0];
      assign out_remainder = rem_w[FIELD_W-1:0];
    end else if (WIDTH == FIELD_W) begin : g_out_eq
      assign out_quotient  = quo_w;
      assign out_remainder = rem_w;
    end else begin : g_out_ext
      assign out_quotient  = {{(FIELD_W-WIDTH){1'b0}}, quo_w};
      assign out_remainder = {{(FIELD_W-WIDTH){1'b0}}, rem_w};
    end
  endgenerate

  assign out_valid       = stg_valid[WIDTH-1];
  assign out_div_by_zero = dz;

endmodule
